// ===== hw/rtl/set_assoc_cache_tag_lru_fifo_top_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef SET_ASSOC_CACHE_TAG_LRU_FIFO_TOP_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_LRU_FIFO_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset.
`define SAC_ASSERT_IMPL(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define SAC_ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define SAC_ASSERT_IMPL(name, ck, rn, ante, cons)
`define SAC_ASSERT_NEXT(name, ck, rn, ante, cons)

`endif

`endif

// ===== hw/rtl/sac_tlf_pkg.sv =====
package sac_tlf_pkg;

    localparam int ADDR_W    = 48;
    localparam int TAG_W     = 48;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 8;
    // widest masked set value: set_bits is at most 15
    localparam int SETV_W    = 15;

    localparam logic       POLICY_LRU  = 1'b0;
    localparam logic       POLICY_FIFO = 1'b1;
    localparam logic       OP_READ     = 1'b0;
    localparam logic       OP_WRITE    = 1'b1;

    localparam logic [4:0] OFFSET_BITS_RST = 5'd6;
    localparam logic [3:0] SET_BITS_RST    = 4'd0;
    localparam logic [3:0] WAYS_RST        = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY,
        CFG_OFFSET_BITS,
        CFG_SET_BITS,
        CFG_WAYS_IN_USE
    } cfg_idx_t;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] address;
    } cache_req_t;

    typedef struct packed {
        logic             hit;
        logic             fetch_from_memory;
        logic             write_to_memory;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] read_total;
        logic [CNT_W-1:0] write_total;
    } cache_rsp_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== hw/rtl/set_assoc_cache_tag_lru_fifo_top.sv =====
// Tag store of a write-through set-associative cache, LRU or FIFO order.
// Channels: in (valid/ready, cache_req_t: op + byte address), out
// (valid/ready, cache_rsp_t: hit, fetch, write flags + four saturating
// totals), cfg (valid/ready write of policy, offset_bits, set_bits,
// ways_in_use by register index; cfg_ready is always high).
// Each set is one row of a single-port-style synchronous memory that holds
// the valid bits and tags of all ways; an access reads the row, compares
// and reorders the ways, and writes the row back.
// Flow: when MAX_SETS is a power of two a beat is accepted with the row
// read, then compared and written back; otherwise the set index goes first
// through a reciprocal multiply (S_DIV) and a correction step (S_IDX).
// A new request is taken only once the lookup of the previous one is done.
// The next request is taken while the previous response still waits in the
// output register; a stalled receiver holds the block in its compare cycle
// until the output register frees, with the row read held meanwhile.
// Reset: totals clear, registers take their defaults, and a clearing pass
// zeroes the valid bits of all MAX_SETS rows, one row per cycle, while
// in_ready stays low.
`include "set_assoc_cache_tag_lru_fifo_top_defines.svh"

module set_assoc_cache_tag_lru_fifo_top #(
    parameter int MAX_SETS  = 256,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sac_tlf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sac_tlf_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sac_tlf_pkg::cache_req_t           in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sac_tlf_pkg::cache_rsp_t           out_data
);
    import sac_tlf_pkg::*;

    localparam int  WC_W      = $clog2(MAX_WAYS + 1);
    localparam int  SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int  ROW_W     = MAX_WAYS * (TAG_W + 1);
    localparam bit  SETS_POW2 = ((MAX_SETS & (MAX_SETS - 1)) == 0);
    localparam int  RECIP     = 65536 / MAX_SETS;
    localparam int  KEEP_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - KEEP_BITS);
    localparam logic [SETV_W-1:0] SETS_V    = SETV_W'(MAX_SETS);
    localparam logic [SETV_W-1:0] SET_MASK  = SETV_W'(MAX_SETS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_IDX,
        S_LOOK
    } state_t;

    // configuration
    logic             policy_reg;
    logic [4:0]       offset_bits_reg;
    logic [3:0]       set_bits_reg;
    logic [3:0]       ways_reg;
    logic [WC_W-1:0]  ways_eff;

    // control
    state_t           state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    cache_rsp_t       out_data_reg, out_data_next;
    logic [CNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0] miss_cnt_reg, miss_cnt_next;
    logic [CNT_W-1:0] read_cnt_reg, read_cnt_next;
    logic [CNT_W-1:0] write_cnt_reg, write_cnt_next;
    logic             clr_busy_reg;
    logic [SET_W-1:0] clr_idx_reg;

    // request payload
    logic              req_op_reg;
    logic [TAG_W-1:0]  req_tag_reg;
    logic [SETV_W-1:0] req_v_reg;
    logic [SETV_W-1:0] q_reg;
    logic [SET_W-1:0]  idx_reg;

    // address split
    logic [ADDR_W-1:0] addr_m;
    logic [ADDR_W-1:0] block;
    logic [15:0]       set_mask16;
    logic [SETV_W-1:0] v_in;
    logic [TAG_W-1:0]  tag_in;
    logic [SET_W-1:0]  idx_in;
    logic [31:0]       prod;
    logic [31:0]       qm;
    logic [SETV_W-1:0] diff;
    logic [SETV_W-1:0] rem;
    logic [SET_W-1:0]  idx_mod;

    // set memory
    logic [ROW_W-1:0]  mem [MAX_SETS];
    logic [ROW_W-1:0]  rdata_reg;
    logic              rd_en;
    logic [SET_W-1:0]  rd_addr;
    logic              wr_en;
    logic [SET_W-1:0]  wr_addr;
    logic [ROW_W-1:0]  wr_data;
    logic [ROW_W-1:0]  upd_row;

    // way update
    logic [MAX_WAYS-1:0] row_vld;
    logic [TAG_W-1:0]    row_tags [MAX_WAYS];
    logic                upd_hit;
    logic [MAX_WAYS-1:0] new_vld;
    logic [TAG_W-1:0]    new_tags [MAX_WAYS];

    logic in_accept;
    logic look_adv;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && !clr_busy_reg;
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign look_adv  = (state_reg == S_LOOK) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg      <= POLICY_LRU;
            offset_bits_reg <= OFFSET_BITS_RST;
            set_bits_reg    <= SET_BITS_RST;
            ways_reg        <= WAYS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POLICY:      policy_reg      <= cfg_data[0];
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_data[4:0];
                CFG_SET_BITS:    set_bits_reg    <= cfg_data[3:0];
                CFG_WAYS_IN_USE: ways_reg        <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    // zero ways acts as one, too many acts as MAX_WAYS
    always_comb
    begin
        if (ways_reg == 4'd0)
            ways_eff = WC_W'(1);
        else if (int'(ways_reg) > MAX_WAYS)
            ways_eff = WC_W'(MAX_WAYS);
        else
            ways_eff = WC_W'(ways_reg);
    end

    // offset / set / tag split of the incoming address
    always_comb
    begin
        addr_m     = in_data.address & ADDR_MASK;
        block      = addr_m >> offset_bits_reg;
        set_mask16 = (16'(1) << set_bits_reg) - 16'(1);
        v_in       = block[SETV_W-1:0] & set_mask16[SETV_W-1:0];
        tag_in     = block >> set_bits_reg;
        idx_in     = SET_W'(v_in & SET_MASK);
    end

    // set value mod MAX_SETS: q is floor or one below, one correction step
    always_comb
    begin
        prod    = 32'(req_v_reg) * 32'(RECIP);
        qm      = 32'(q_reg) * 32'(MAX_SETS);
        diff    = req_v_reg - qm[SETV_W-1:0];
        rem     = (diff >= SETS_V) ? diff - SETS_V : diff;
        idx_mod = SET_W'(rem);
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_in;
        if (in_accept && SETS_POW2)
            rd_en = 1'b1;
        if (state_reg == S_IDX)
        begin
            rd_en   = 1'b1;
            rd_addr = idx_mod;
        end
    end

    always_comb
    begin
        row_vld = rdata_reg[MAX_WAYS-1:0];
        for (int i = 0; i < MAX_WAYS; i++)
            row_tags[i] = rdata_reg[MAX_WAYS + i*TAG_W +: TAG_W];
    end

    sac_tlf_way_update #(
        .MAX_WAYS (MAX_WAYS)
    ) u_way_update (
        .policy   (policy_reg),
        .ways     (ways_eff),
        .tag      (req_tag_reg),
        .vld      (row_vld),
        .tags     (row_tags),
        .hit      (upd_hit),
        .new_vld  (new_vld),
        .new_tags (new_tags)
    );

    always_comb
    begin
        upd_row[MAX_WAYS-1:0] = new_vld;
        for (int i = 0; i < MAX_WAYS; i++)
            upd_row[MAX_WAYS + i*TAG_W +: TAG_W] = new_tags[i];
    end

    // clearing pass owns the write port after reset
    always_comb
    begin
        if (clr_busy_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = look_adv;
            wr_addr = idx_reg;
            wr_data = upd_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_op_reg  <= in_data.op;
            req_tag_reg <= tag_in;
            req_v_reg   <= v_in;
            idx_reg     <= idx_in;
        end
        if (state_reg == S_DIV)
            q_reg <= prod[16 +: SETV_W];
        if (state_reg == S_IDX)
            idx_reg <= idx_mod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (int'(clr_idx_reg) == MAX_SETS - 1)
                clr_busy_reg <= 1'b0;
            else
                clr_idx_reg <= clr_idx_reg + SET_W'(1);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        read_cnt_next  = read_cnt_reg;
        write_cnt_next = write_cnt_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = SETS_POW2 ? S_LOOK : S_DIV;
            end
            S_DIV:
                state_next = S_IDX;
            S_IDX:
                state_next = S_LOOK;
            S_LOOK:
            begin
                if (look_adv)
                begin
                    if (upd_hit)
                        hit_cnt_next = sat_inc(hit_cnt_reg);
                    else
                    begin
                        miss_cnt_next = sat_inc(miss_cnt_reg);
                        read_cnt_next = sat_inc(read_cnt_reg);
                    end
                    if (req_op_reg == OP_WRITE)
                        write_cnt_next = sat_inc(write_cnt_reg);

                    out_valid_next                  = 1'b1;
                    out_data_next.hit               = upd_hit;
                    out_data_next.fetch_from_memory = !upd_hit;
                    out_data_next.write_to_memory   = (req_op_reg == OP_WRITE);
                    out_data_next.hit_total         = hit_cnt_next;
                    out_data_next.miss_total        = miss_cnt_next;
                    out_data_next.read_total        = read_cnt_next;
                    out_data_next.write_total       = write_cnt_next;
                    state_next                      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            read_cnt_reg  <= '0;
            write_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            read_cnt_reg  <= read_cnt_next;
            write_cnt_reg <= write_cnt_next;
        end
    end

    // a request beat always starts a lookup
    `SAC_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_accept, state_reg != S_IDLE)
    // every miss fetches, so the two totals move together
    `SAC_ASSERT_IMPL(a_miss_eq_read, clk, rst_n, out_valid_reg,
                     out_data_reg.miss_total == out_data_reg.read_total)
    // a response is either a hit or a fetch, never both
    `SAC_ASSERT_IMPL(a_hit_xor_fetch, clk, rst_n, out_valid_reg,
                     out_data_reg.hit != out_data_reg.fetch_from_memory)
    // row read and write-back never share a cycle
    `SAC_ASSERT_IMPL(a_no_rw_overlap, clk, rst_n, wr_en, !rd_en)

endmodule

// ===== hw/rtl/sac_tlf_way_update.sv =====
module sac_tlf_way_update #(
    parameter int MAX_WAYS = 8
) (
    input  logic                           policy,
    input  logic [$clog2(MAX_WAYS+1)-1:0]  ways,
    input  logic [sac_tlf_pkg::TAG_W-1:0]  tag,
    input  logic [MAX_WAYS-1:0]            vld,
    input  logic [sac_tlf_pkg::TAG_W-1:0]  tags     [MAX_WAYS],
    output logic                           hit,
    output logic [MAX_WAYS-1:0]            new_vld,
    output logic [sac_tlf_pkg::TAG_W-1:0]  new_tags [MAX_WAYS]
);
    import sac_tlf_pkg::*;

    localparam int WI_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] live;
    logic [MAX_WAYS-1:0] match;
    logic [MAX_WAYS-1:0] free;
    logic [WI_W-1:0]     hit_idx;
    logic [WI_W-1:0]     free_idx;
    logic [WI_W-1:0]     last_idx;
    logic [WI_W-1:0]     lo_idx;
    logic [WI_W-1:0]     hi_idx;
    logic                has_free;
    logic                do_move;

    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            in_use[i] = (i < int'(ways));
            live[i]   = in_use[i] && vld[i];
            match[i]  = live[i] && (tags[i] == tag);
            free[i]   = in_use[i] && !vld[i];
        end
        hit      = |match;
        has_free = |free;

        // lowest matching / lowest free way
        hit_idx  = '0;
        free_idx = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (match[i])
                hit_idx = WI_W'(i);
            if (free[i])
                free_idx = WI_W'(i);
        end

        // LRU move stops before the first gap above the hit
        last_idx = WI_W'(int'(ways) - 1);
        for (int i = MAX_WAYS - 1; i >= 1; i--)
        begin
            if (i > int'(hit_idx) && !live[i])
                last_idx = WI_W'(i - 1);
        end

        do_move = 1'b1;
        lo_idx  = '0;
        hi_idx  = WI_W'(int'(ways) - 1);
        new_vld = vld;
        if (hit)
        begin
            do_move = (policy == POLICY_LRU);
            lo_idx  = hit_idx;
            hi_idx  = last_idx;
        end
        else if (has_free)
        begin
            lo_idx            = free_idx;
            hi_idx            = free_idx;
            new_vld[free_idx] = 1'b1;
        end

        new_tags = tags;
        for (int i = 0; i < MAX_WAYS - 1; i++)
        begin
            if (do_move && i >= int'(lo_idx) && i < int'(hi_idx))
                new_tags[i] = tags[i + 1];
        end
        if (do_move)
            new_tags[hi_idx] = tag;
    end

endmodule
